[src/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg: shared types and sizes for the sorted run placement block
// Table sizes, result word layout and the request bundles toward the RAMs.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int MaxRuns   = 256;
    localparam int ValueBits = 32;
    localparam int MaxRunLen = 65535;

    localparam int IdxW = $clog2(MaxRuns);
    localparam int CntW = $clog2(MaxRuns + 1);
    localparam int LenW = $clog2(MaxRunLen + 1);
    localparam int KeyW = ValueBits;
    localparam int HbW  = KeyW + LenW;

    localparam int RunIdxBits = 8;
    localparam int RunLenBits = 16;
    localparam int RunCntBits = 9;
    localparam int PlaceBits  = 3;

    typedef enum logic [PlaceBits-1:0] {
        PL_APPEND  = 3'd0,
        PL_PREPEND = 3'd1,
        PL_NEW     = 3'd2,
        PL_FULL    = 3'd3,
        PL_CLEAR   = 3'd4
    } t_place;

    typedef struct packed {
        logic [RunIdxBits-1:0] run_index;
        t_place                placement;
        logic [RunLenBits-1:0] run_length;
        logic [RunCntBits-1:0] run_count;
        logic                  set_done;
    } t_result;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        logic [KeyW-1:0] wdata;
        logic            re;
        logic [IdxW-1:0] raddr;
    } t_tail_req;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        logic [HbW-1:0]  wdata;
        logic            re;
        logic [IdxW-1:0] raddr;
    } t_hb_req;

endpackage

[src/srp_ram.sv]
// ----------------------------------------------------------------------------
// srp_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data held while idle.
// ----------------------------------------------------------------------------
module srp_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/srp_seq.sv]
// ----------------------------------------------------------------------------
// srp_seq: placement sequencer
// Runs the two binary searches over the tail and head RAMs, then reads, updates
// and writes back the chosen run entry; a clear command resets the run count.
// ----------------------------------------------------------------------------
module srp_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [srp_pkg::KeyW-1:0]      i_key,
    input  logic                          i_last_item,
    output srp_pkg::t_tail_req            o_tail_req,
    input  logic [srp_pkg::KeyW-1:0]      i_tail_rdata,
    output srp_pkg::t_hb_req              o_hb_req,
    input  logic [srp_pkg::HbW-1:0]       i_hb_rdata,
    input  logic                          i_res_free,
    output logic                          o_res_valid,
    output srp_pkg::t_result              o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    localparam int CntW = srp_pkg::CntW;
    localparam int IdxW = srp_pkg::IdxW;
    localparam int LenW = srp_pkg::LenW;
    localparam int KeyW = srp_pkg::KeyW;

    function automatic logic [CntW-1:0] mid_of(logic [CntW-1:0] lo, logic [CntW-1:0] hi);
        logic [CntW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[CntW:1];
    endfunction

    function automatic logic [LenW-1:0] grow(logic [LenW-1:0] len);
        logic [LenW-1:0] res;
        if (len >= LenW'(srp_pkg::MaxRunLen)) begin
            res = LenW'(srp_pkg::MaxRunLen);
        end else begin
            res = len + LenW'(1);
        end
        return res;
    endfunction

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [KeyW-1:0]     r_key, n_key;
    logic                r_done, n_done;
    logic [CntW-1:0]     r_lo_t, n_lo_t, r_hi_t, n_hi_t;
    logic [CntW-1:0]     r_lo_h, n_lo_h, r_hi_h, n_hi_h;
    srp_pkg::t_place     r_kind, n_kind;
    logic [IdxW-1:0]     r_idx, n_idx;

    logic [CntW-1:0]     mid_t, mid_h, nmid_t, nmid_h;
    logic [KeyW-1:0]     hb_head;
    logic [LenW-1:0]     hb_len, len_next;
    logic                accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);
    assign mid_t   = mid_of(r_lo_t, r_hi_t);
    assign mid_h   = mid_of(r_lo_h, r_hi_h);
    assign hb_head = i_hb_rdata[srp_pkg::HbW-1:LenW];
    assign hb_len  = i_hb_rdata[LenW-1:0];
    assign len_next = grow(hb_len);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_key   = r_key;
        n_done  = r_done;
        n_lo_t  = r_lo_t;
        n_hi_t  = r_hi_t;
        n_lo_h  = r_lo_h;
        n_hi_h  = r_hi_h;
        n_kind  = r_kind;
        n_idx   = r_idx;
        nmid_t  = '0;
        nmid_h  = '0;
        o_tail_req  = '0;
        o_hb_req    = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key  = i_key;
                    n_done = i_last_item;
                    if (i_command) begin
                        n_kind  = srp_pkg::PL_CLEAR;
                        n_state = ST_FINISH;
                    end else begin
                        // Open both searches over [0, count) and issue the first probes
                        n_lo_t = '0;
                        n_hi_t = r_cnt;
                        n_lo_h = '0;
                        n_hi_h = r_cnt;
                        nmid_t = mid_of('0, r_cnt);
                        o_tail_req.re    = (r_cnt != '0);
                        o_tail_req.raddr = nmid_t[IdxW-1:0];
                        o_hb_req.re      = (r_cnt != '0);
                        o_hb_req.raddr   = nmid_t[IdxW-1:0];
                        n_state = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                // Narrow each search on the probe that just returned
                if (r_lo_t < r_hi_t) begin
                    if (i_tail_rdata < r_key) begin
                        n_hi_t = mid_t;
                    end else begin
                        n_lo_t = mid_t + CntW'(1);
                    end
                end
                if (r_lo_h < r_hi_h) begin
                    if (hb_head >= r_key) begin
                        n_hi_h = mid_h;
                    end else begin
                        n_lo_h = mid_h + CntW'(1);
                    end
                end
                nmid_t = mid_of(n_lo_t, n_hi_t);
                nmid_h = mid_of(n_lo_h, n_hi_h);
                if ((n_lo_t < n_hi_t) || (n_lo_h < n_hi_h)) begin
                    o_tail_req.re    = (n_lo_t < n_hi_t);
                    o_tail_req.raddr = nmid_t[IdxW-1:0];
                    o_hb_req.re      = (n_lo_h < n_hi_h);
                    o_hb_req.raddr   = nmid_h[IdxW-1:0];
                end else begin
                    // Both searches settled: pick the rule, fetch the entry
                    if (n_lo_t < r_cnt) begin
                        n_kind = srp_pkg::PL_APPEND;
                        n_idx  = n_lo_t[IdxW-1:0];
                    end else if (n_lo_h < r_cnt) begin
                        n_kind = srp_pkg::PL_PREPEND;
                        n_idx  = n_lo_h[IdxW-1:0];
                    end else if (r_cnt == CntW'(srp_pkg::MaxRuns)) begin
                        n_kind = srp_pkg::PL_FULL;
                        n_idx  = '0;
                    end else begin
                        n_kind = srp_pkg::PL_NEW;
                        n_idx  = r_cnt[IdxW-1:0];
                    end
                    o_hb_req.re    = 1'b1;
                    o_hb_req.raddr = n_idx;
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (i_res_free) begin
                    o_res_valid    = 1'b1;
                    o_res.set_done = r_done;
                    o_res.placement = r_kind;
                    case (r_kind)
                        srp_pkg::PL_APPEND: begin
                            o_tail_req.we    = 1'b1;
                            o_tail_req.waddr = r_idx;
                            o_tail_req.wdata = r_key;
                            o_hb_req.we      = 1'b1;
                            o_hb_req.waddr   = r_idx;
                            o_hb_req.wdata   = {hb_head, len_next};
                            o_res.run_index  = srp_pkg::RunIdxBits'(r_idx);
                            o_res.run_length = srp_pkg::RunLenBits'(len_next);
                        end
                        srp_pkg::PL_PREPEND: begin
                            o_hb_req.we      = 1'b1;
                            o_hb_req.waddr   = r_idx;
                            o_hb_req.wdata   = {r_key, len_next};
                            o_res.run_index  = srp_pkg::RunIdxBits'(r_idx);
                            o_res.run_length = srp_pkg::RunLenBits'(len_next);
                        end
                        srp_pkg::PL_NEW: begin
                            o_tail_req.we    = 1'b1;
                            o_tail_req.waddr = r_idx;
                            o_tail_req.wdata = r_key;
                            o_hb_req.we      = 1'b1;
                            o_hb_req.waddr   = r_idx;
                            o_hb_req.wdata   = {r_key, LenW'(1)};
                            n_cnt            = r_cnt + CntW'(1);
                            o_res.run_index  = srp_pkg::RunIdxBits'(r_idx);
                            o_res.run_length = srp_pkg::RunLenBits'(1);
                        end
                        srp_pkg::PL_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                            // table full: drop the value, state untouched
                        end
                    endcase
                    o_res.run_count = srp_pkg::RunCntBits'(n_cnt);
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_key  <= n_key;
        r_done <= n_done;
        r_lo_t <= n_lo_t;
        r_hi_t <= n_hi_t;
        r_lo_h <= n_lo_h;
        r_hi_h <= n_hi_h;
        r_kind <= n_kind;
        r_idx  <= n_idx;
    end

endmodule

[src/sorted_run_placement.sv]
// ----------------------------------------------------------------------------
// sorted_run_placement: run-forming stage of a patience-style sort
// Places each signed value into a run and reports where it went.
// ----------------------------------------------------------------------------
// One item at a time. A value is biased (sign bit flipped) and searched for
// in two RAMs at once: the tail RAM (tails kept in descending order) and the
// head/length RAM (heads kept in ascending order). Each search is a binary
// search that issues one probe per cycle. The chosen entry is then read,
// its length bumped with saturation, and written back. The RAMs are not
// cleared: only entries below the open-run count are ever used. The result
// word sits in an output register, so the next item is taken while a result
// waits.
// ----------------------------------------------------------------------------
module sorted_run_placement (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic signed [srp_pkg::ValueBits-1:0] i_value,
    input  logic                               i_last_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [srp_pkg::RunIdxBits-1:0]     o_run_index,
    output logic [srp_pkg::PlaceBits-1:0]      o_placement,
    output logic [srp_pkg::RunLenBits-1:0]     o_run_length,
    output logic [srp_pkg::RunCntBits-1:0]     o_run_count,
    output logic                               o_set_done
);

    logic [srp_pkg::KeyW-1:0] key;
    srp_pkg::t_tail_req       tail_req;
    srp_pkg::t_hb_req         hb_req;
    logic [srp_pkg::KeyW-1:0] tail_rdata;
    logic [srp_pkg::HbW-1:0]  hb_rdata;
    logic                     res_valid;
    logic                     res_free;
    srp_pkg::t_result         res;
    srp_pkg::t_result         r_out;
    logic                     r_out_valid;

    // Flip the sign bit so unsigned compares follow signed order
    assign key = {~i_value[srp_pkg::ValueBits-1], i_value[srp_pkg::ValueBits-2:0]};

    // Output slot is free when empty or being drained this cycle
    assign res_free = !r_out_valid || !i_out_stall;

    srp_ram #(
        .Width (srp_pkg::KeyW),
        .Depth (srp_pkg::MaxRuns)
    ) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_req.we),
        .i_waddr (tail_req.waddr),
        .i_wdata (tail_req.wdata),
        .i_re    (tail_req.re),
        .i_raddr (tail_req.raddr),
        .o_rdata (tail_rdata)
    );

    // Head and length share one entry: {head, length}
    srp_ram #(
        .Width (srp_pkg::HbW),
        .Depth (srp_pkg::MaxRuns)
    ) u_hb_ram (
        .i_clk   (i_clk),
        .i_we    (hb_req.we),
        .i_waddr (hb_req.waddr),
        .i_wdata (hb_req.wdata),
        .i_re    (hb_req.re),
        .i_raddr (hb_req.raddr),
        .o_rdata (hb_rdata)
    );

    srp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_command    (i_command),
        .i_key        (key),
        .i_last_item  (i_last_item),
        .o_tail_req   (tail_req),
        .i_tail_rdata (tail_rdata),
        .o_hb_req     (hb_req),
        .i_hb_rdata   (hb_rdata),
        .i_res_free   (res_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_index  = r_out.run_index;
    assign o_placement  = r_out.placement;
    assign o_run_length = r_out.run_length;
    assign o_run_count  = r_out.run_count;
    assign o_set_done   = r_out.set_done;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer took an item but did not go busy");

    a_clear_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_placement == srp_pkg::PL_CLEAR) |->
        (o_run_count == '0 && o_run_length == '0 && o_run_index == '0))
        else $error("clear word carries nonzero fields");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_placement == srp_pkg::PL_FULL) |->
        (o_run_count == srp_pkg::RunCntBits'(srp_pkg::MaxRuns) && o_run_length == '0))
        else $error("rejected value while the run table is not full");

    a_placed_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_placement == srp_pkg::PL_APPEND ||
                         o_placement == srp_pkg::PL_PREPEND ||
                         o_placement == srp_pkg::PL_NEW)) |->
        ({1'b0, o_run_index} < o_run_count && o_run_length != '0))
        else $error("placed value points outside the open runs");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_run_placement
// Drives place and clear words through the valid/stall input channel, keeps a
// shadow of the run tables and checks every result word against it in order.
// ----------------------------------------------------------------------------
module tb;
    import srp_pkg::*;

    // A result may wait out a stall burst, the sender may pause and a binary
    // search may be running; this is far beyond all three.
    localparam int QuietLimit  = 5000;
    localparam int DrainCycles = 40;

    localparam logic signed [ValueBits-1:0] MinVal = {1'b1, {(ValueBits-1){1'b0}}};
    localparam logic signed [ValueBits-1:0] MaxVal = {1'b0, {(ValueBits-1){1'b1}}};

    // Shadow of the run tables: tails, heads and lengths per open run, and the
    // queue of result words that the block still owes.
    class run_book;
        logic signed [ValueBits-1:0] tails [MaxRuns];
        logic signed [ValueBits-1:0] heads [MaxRuns];
        logic [LenW-1:0]             lens  [MaxRuns];
        int                          open_cnt;
        t_result                     owed_words [$];
        int                          faults;

        function new();
            open_cnt = 0;
            faults   = 0;
        endfunction

        // Note one accepted input word and queue the result it must produce.
        function void place_word(bit cmd, logic signed [ValueBits-1:0] val, bit last);
            t_result want;
            int      hit;
            want.run_index  = '0;
            want.run_length = '0;
            want.set_done   = last;
            hit = -1;
            if (cmd) begin
                open_cnt = 0;
                want.placement = PL_CLEAR;
            end else begin
                // First run whose tail lies strictly below the value.
                for (int i = 0; i < open_cnt && hit < 0; i++)
                    if (tails[i] < val) hit = i;
                if (hit >= 0) begin
                    tails[hit] = val;
                    want.placement = PL_APPEND;
                end else begin
                    // First run whose head is at least the value.
                    for (int i = 0; i < open_cnt && hit < 0; i++)
                        if (heads[i] >= val) hit = i;
                    if (hit >= 0) begin
                        heads[hit] = val;
                        want.placement = PL_PREPEND;
                    end else if (open_cnt < MaxRuns) begin
                        hit = open_cnt;
                        tails[hit] = val;
                        heads[hit] = val;
                        lens[hit]  = '0;
                        open_cnt++;
                        want.placement = PL_NEW;
                    end else begin
                        want.placement = PL_FULL;
                    end
                end
                if (hit >= 0) begin
                    if (lens[hit] < LenW'(MaxRunLen)) lens[hit] = lens[hit] + 1'b1;
                    want.run_index  = RunIdxBits'(hit);
                    want.run_length = RunLenBits'(lens[hit]);
                end
            end
            want.run_count = RunCntBits'(open_cnt);
            owed_words = {owed_words, want};
        endfunction

        // Compare one accepted result word with the oldest owed word.
        function void check_word(t_result got);
            t_result want;
            if (owed_words.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: idx %0d place %0d len %0d cnt %0d done %0d",
                             got.run_index, got.placement, got.run_length,
                             got.run_count, got.set_done);
                return;
            end
            want = owed_words.pop_front();
            if (got.run_index  !== want.run_index  ||
                got.placement  !== want.placement  ||
                got.run_length !== want.run_length ||
                got.run_count  !== want.run_count  ||
                got.set_done   !== want.set_done) begin
                faults++;
                if (faults <= 10)
                    $display({"result differs (expected/actual): idx %0d/%0d place %0d/%0d",
                              " len %0d/%0d cnt %0d/%0d done %0d/%0d"},
                             want.run_index, got.run_index, want.placement, got.placement,
                             want.run_length, got.run_length, want.run_count,
                             got.run_count, want.set_done, got.set_done);
            end
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic                        i_command   = 1'b0;
    logic signed [ValueBits-1:0] i_value     = '0;
    logic                        i_last_item = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [RunIdxBits-1:0]       o_run_index;
    logic [PlaceBits-1:0]        o_placement;
    logic [RunLenBits-1:0]       o_run_length;
    logic [RunCntBits-1:0]       o_run_count;
    logic                        o_set_done;

    run_book book = new();

    // Idling on both channels is allowed only while this is set.
    bit idle_on    = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    sorted_run_placement u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_last_item  (i_last_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_run_index  (o_run_index),
        .o_placement  (o_placement),
        .o_run_length (o_run_length),
        .o_run_count  (o_run_count),
        .o_set_done   (o_set_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one word and hold it until the block takes it. A random pause may
    // come first; valid drops only in that pause, so it is never lowered and
    // raised in the same step.
    task automatic send_word(bit cmd, logic signed [ValueBits-1:0] val, bit last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_value     <= val;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.place_word(cmd, val, last);
    endtask

    // Value shapes for one data set: fully random, a narrow band full of
    // repeats, a rising ramp with jitter, or the extremes mixed with noise.
    function automatic logic signed [ValueBits-1:0] pick_value(int shape, int k);
        int pick;
        case (shape)
            1: return $urandom_range(0, 16) - 8;
            2: return k * 64 + $urandom_range(0, 200) - 3000;
            3: begin
                pick = $urandom_range(0, 4);
                if (pick == 0) return MinVal;
                if (pick == 1) return MaxVal;
                if (pick == 2) return 0;
                if (pick == 3) return -1;
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // Well-formed data sets: a clear, then placements with last_item on the
    // final one. Now and then a stray clear or an early last_item breaks the
    // pattern.
    task automatic run_data_sets(int budget);
        int sent;
        int count;
        int shape;
        sent = 0;
        while (sent < budget) begin
            send_word(1'b1, $urandom, $urandom_range(0, 7) == 0);
            count = $urandom_range(1, 48);
            shape = $urandom_range(0, 3);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 39) == 0)
                    send_word(1'b1, $urandom, $urandom_range(0, 1));
                else
                    send_word(1'b0, pick_value(shape, k),
                              (k == count - 1) || ($urandom_range(0, 19) == 0));
                sent++;
            end
        end
    endtask

    // Receive side: check each accepted result, then decide the stall for
    // the next cycle. Stalls come in random bursts.
    always @(posedge i_clk) begin
        t_result seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen.run_index  = o_run_index;
                seen.placement  = t_place'(o_placement);
                seen.run_length = o_run_length;
                seen.run_count  = o_run_count;
                seen.set_done   = o_set_done;
                book.check_word(seen);
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 6);
            i_out_stall <= (stall_left > 0);
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && !((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // Hold reset, then release it at an edge.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: extremes, each placement kind but full, equal heads, a
        // clear whose value must be ignored and whose last_item still shows.
        send_word(1'b1, 0, 1'b0);
        send_word(1'b0, MinVal, 1'b0);        // new run 0
        send_word(1'b0, MaxVal, 1'b0);        // append to run 0
        send_word(1'b0, 0, 1'b0);             // new run 1 between head and tail
        send_word(1'b0, 0, 1'b0);             // equal head: prepend run 1
        send_word(1'b0, -1, 1'b0);            // prepend run 1
        send_word(1'b0, 1, 1'b0);             // append run 1
        send_word(1'b0, MinVal, 1'b0);        // equal head at minimum: prepend run 0
        send_word(1'b0, MaxVal, 1'b1);        // append run 1, end of set
        send_word(1'b1, 32'hFFFF_FFFF, 1'b1); // clear, value ignored
        send_word(1'b0, 5, 1'b1);
        send_word(1'b1, 32'h5555_5555, 1'b0);
        send_word(1'b0, 32'hAAAA_AAAA, 1'b0);
        send_word(1'b0, 32'h5555_5555, 1'b1);

        // Fill the run table: each pair opens a run just inside the previous
        // one and widens it, so all 256 runs open with nested ranges.
        send_word(1'b1, $urandom, 1'b0);
        for (int k = 0; k < MaxRuns; k++) begin
            send_word(1'b0, MinVal + k, 1'b0);
            send_word(1'b0, MaxVal - k, 1'b0);
        end
        // Table full: values in the middle are rejected, the edges still fit.
        send_word(1'b0, MinVal + MaxRuns, 1'b0);
        send_word(1'b0, MaxVal - MaxRuns, 1'b0);
        send_word(1'b0, 0, 1'b0);
        send_word(1'b0, MinVal, 1'b0);
        send_word(1'b0, MaxVal, 1'b0);
        for (int k = 0; k < 20; k++)
            send_word(1'b0, $urandom, k == 19);

        // Random data sets with idling on both sides.
        run_data_sets(800);

        // Last part without idling: grow one run with a strictly rising
        // sequence, then a few more data sets.
        idle_on = 1'b0;
        send_word(1'b1, $urandom, 1'b0);
        for (int k = 0; k < 40; k++)
            send_word(1'b0, MinVal + k, k == 39);
        run_data_sets(200);

        // Drain: wait for every owed result, then a few quiet cycles.
        i_in_valid <= 1'b0;
        while (book.owed_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (book.faults == 0 && book.owed_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
